FILE: rtl/clws_pkg.sv
// Package of the command line word splitter: codes, constants and the result record.
package clws_pkg;

   localparam int LINE_BYTES_DEFAULT = 256;
   localparam int CHAR_W = 8;
   localparam int POS_W_OUT = 8;
   localparam int COUNT_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5c;

   localparam logic [COUNT_W-1:0] WORD_LIMIT_RESET = 8'd20;
   localparam logic [COUNT_W-1:0] WORDS_MAX = 8'd255;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_SQUOTE  = 3'd2,
      MODE_DQUOTE  = 3'd3,
      MODE_ESCAPE  = 3'd4
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0]    out_byte;
      logic [POS_W_OUT-1:0] out_pos;
      logic [COUNT_W-1:0]   word_total;
      logic                 starts_word;
      logic                 is_summary;
      logic                 rejected;
      logic                 too_long;
   } rsp_type;

endpackage

FILE: rtl/command_line_word_splitter_top.sv
// Top level of the command line word splitter: parser state and result queue.
//
//   Channel   Direction   Handshake               Content
//   req_      in          req_tvalid/req_tready   one command line byte
//   rsp_      out         rsp_tvalid/rsp_tready   packed byte or end-of-line summary
//   csr_      in          csr_valid/csr_ready     word limit register
//
// Each request is parsed in the cycle it is accepted and its results are written
// into a four-entry result queue, which drives the result channel from registers.
// A request is accepted in every cycle while the queue has room for two results,
// so a steady stream of one result per request runs at one request per cycle; a
// line end that closes a word yields two results.
// Reset clears the parse state, the queue and sets the word limit to twenty.
// A stalled result channel fills the queue and then holds off further requests.
module command_line_word_splitter_top #(
   parameter int LINE_BYTES = clws_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // char_in [7:0]
   input  logic [clws_pkg::CHAR_W-1:0]        req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_byte [7:0], out_pos [15:8], word_total [23:16]
   output logic [clws_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // starts_word [0], rejected [1], too_long [2]
   output logic [clws_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [clws_pkg::COUNT_W-1:0]       csr_data
);
   import clws_pkg::*;

   localparam int POS_W = $clog2(LINE_BYTES);
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(LINE_BYTES - 1);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] ACCEPT_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

   mode_type             mode_ff, mode_in;
   mode_type             resume_ff, resume_in;
   logic [COUNT_W-1:0]   words_ff, words_in;
   logic [POS_W-1:0]     wpos_ff, wpos_in;
   logic                 fresh_ff, fresh_in;
   logic                 ovf_ff, ovf_in;
   logic                 top_taken_ff, top_taken_in;
   logic [COUNT_W-1:0]   limit_ff;

   rsp_type              queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 req_fire, rsp_fire;
   logic [CHAR_W-1:0]    c;
   logic                 line_end;
   logic                 do_put, put_ends_word;
   logic [CHAR_W-1:0]    put_val;
   logic                 at_top, ovf_after;
   logic [COUNT_W-1:0]   words_after;
   logic                 rej;
   rsp_type              put_ent, sum_ent, ent0, ent1;
   logic [1:0]           push_cnt;
   logic [PTR_W-1:0]     wr_ptr_next;
   rsp_type              head;

   assign csr_ready = 1'b1;
   assign req_tready = (count_ff <= ACCEPT_LIMIT);
   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;
   assign c = req_tdata;
   assign line_end = (c == CHAR_NUL) || (c == CHAR_CR);

   // Parse step: mode transitions and choice of the byte to write.
   always_comb begin
      mode_in = mode_ff;
      resume_in = resume_ff;
      do_put = 1'b0;
      put_ends_word = 1'b0;
      put_val = c;
      if (line_end) begin
         do_put = (mode_ff != MODE_BETWEEN);
         put_ends_word = 1'b1;
         put_val = CHAR_NUL;
         mode_in = MODE_BETWEEN;
         resume_in = MODE_BETWEEN;
      end else begin
         unique case (mode_ff)
            MODE_BETWEEN, MODE_WORD: begin
               if (c == CHAR_DQUOTE) begin
                  mode_in = MODE_DQUOTE;
               end else if (c == CHAR_SQUOTE) begin
                  mode_in = MODE_SQUOTE;
               end else if (c == CHAR_BACKSLASH) begin
                  resume_in = MODE_WORD;
                  mode_in = MODE_ESCAPE;
               end else if (c == CHAR_SPACE) begin
                  if (mode_ff == MODE_WORD) begin
                     do_put = 1'b1;
                     put_ends_word = 1'b1;
                     put_val = CHAR_NUL;
                     mode_in = MODE_BETWEEN;
                  end
               end else begin
                  do_put = 1'b1;
                  mode_in = MODE_WORD;
               end
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
               if ((mode_ff == MODE_SQUOTE && c == CHAR_SQUOTE) ||
                   (mode_ff == MODE_DQUOTE && c == CHAR_DQUOTE)) begin
                  mode_in = MODE_WORD;
               end else if (c == CHAR_BACKSLASH) begin
                  resume_in = mode_ff;
                  mode_in = MODE_ESCAPE;
               end else begin
                  do_put = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               do_put = 1'b1;
               if (resume_ff == MODE_WORD || resume_ff == MODE_SQUOTE ||
                   resume_ff == MODE_DQUOTE) begin
                  mode_in = resume_ff;
               end else begin
                  mode_in = MODE_WORD;
               end
            end
            default: begin
               do_put = 1'b1;
               mode_in = MODE_WORD;
            end
         endcase
      end
   end

   // Buffer write, counters and the results of one request.
   always_comb begin
      at_top = (wpos_ff == POS_TOP);
      ovf_after = ovf_ff | (do_put & at_top & top_taken_ff);
      words_after = words_ff;
      if (do_put && put_ends_word && words_ff != WORDS_MAX) begin
         words_after = words_ff + COUNT_W'(1);
      end
      rej = (words_after >= limit_ff);

      wpos_in = wpos_ff;
      top_taken_in = top_taken_ff;
      fresh_in = fresh_ff;
      ovf_in = ovf_after;
      words_in = words_after;
      if (do_put) begin
         if (!at_top) begin
            wpos_in = wpos_ff + POS_W'(1);
         end
         top_taken_in = top_taken_ff | at_top;
         fresh_in = put_ends_word;
      end

      put_ent = '0;
      put_ent.out_byte = put_val;
      put_ent.out_pos = POS_W_OUT'(wpos_ff);
      put_ent.starts_word = fresh_ff;
      put_ent.too_long = ovf_after;

      sum_ent = '0;
      sum_ent.is_summary = 1'b1;
      sum_ent.word_total = rej ? '0 : words_after;
      sum_ent.rejected = rej;
      sum_ent.too_long = ovf_after;

      if (line_end) begin
         words_in = '0;
         wpos_in = '0;
         fresh_in = 1'b1;
         ovf_in = 1'b0;
         top_taken_in = 1'b0;
      end

      ent0 = put_ent;
      ent1 = sum_ent;
      push_cnt = 2'd0;
      if (req_fire) begin
         if (line_end) begin
            if (do_put) begin
               push_cnt = 2'd2;
            end else begin
               ent0 = sum_ent;
               push_cnt = 2'd1;
            end
         end else if (do_put) begin
            push_cnt = 2'd1;
         end
      end
   end

   // Result queue pointers.
   always_comb begin
      wr_ptr_next = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rsp_fire ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push_cnt) - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         resume_ff <= MODE_BETWEEN;
         words_ff <= '0;
         wpos_ff <= '0;
         fresh_ff <= 1'b1;
         ovf_ff <= 1'b0;
         top_taken_ff <= 1'b0;
         limit_ff <= WORD_LIMIT_RESET;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (req_fire) begin
            mode_ff <= mode_in;
            resume_ff <= resume_in;
            words_ff <= words_in;
            wpos_ff <= wpos_in;
            fresh_ff <= fresh_in;
            ovf_ff <= ovf_in;
            top_taken_ff <= top_taken_in;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= ent0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_next] <= ent1;
      end
   end

   assign head = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata = {head.word_total, head.out_pos, head.out_byte};
   assign rsp_tuser = {head.too_long, head.rejected, head.starts_word};
   assign rsp_tlast = head.is_summary;

endmodule
